// File: rtl/manifest_json_field_parser_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the manifest parser.
// Each macro expects signals named clk and rst_n in the module that uses it.
// ---------------------------------------------------------------------------
`ifndef MANIFEST_JSON_FIELD_PARSER_DEFINES_SVH
`define MANIFEST_JSON_FIELD_PARSER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while in reset.
`define MFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MFP_ASSERT_NOW(lbl, ante, cons, msg)
`define MFP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/mfp_pkg.sv
// ---------------------------------------------------------------------------
// mfp_pkg
// Shared types, character codes and key tables of the manifest parser.
// ---------------------------------------------------------------------------
package mfp_pkg;

  localparam int BYTE_W      = 8;
  localparam int FIELD_W     = 2;
  localparam int CNT_W       = 10;
  localparam int QUEUE_DEPTH = 2;

  // Field codes. FIELD_OTHER marks a key that is none of the known three.
  localparam logic [FIELD_W-1:0] FIELD_VERSION = 2'd0;
  localparam logic [FIELD_W-1:0] FIELD_URL     = 2'd1;
  localparam logic [FIELD_W-1:0] FIELD_SHA     = 2'd2;
  localparam logic [FIELD_W-1:0] FIELD_OTHER   = 2'd3;

  localparam logic [2:0] FIELDS_NONE = 3'b000;
  localparam logic [2:0] FIELDS_ALL  = 3'b111;

  // Character codes.
  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;

  // Key lengths of the known fields.
  localparam logic [CNT_W-1:0] KEY_LEN_VERSION = 10'd7;
  localparam logic [CNT_W-1:0] KEY_LEN_URL     = 10'd3;
  localparam logic [CNT_W-1:0] KEY_LEN_SHA     = 10'd6;

  // Byte classes found by the front end.
  typedef struct packed {
    logic quote;
    logic bslash;
    logic esc_ok;   // quote, backslash or slash: a legal escape
    logic ctrl;     // below 0x20
    logic space;
    logic lbrace;
    logic rbrace;
    logic colon;
    logic comma;
    logic hex;
    logic nul;
  } mfp_cls_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    mfp_cls_t          cls;
  } mfp_item_t;

  // Character idx of the known key k; zero past the end of the key.
  function automatic logic [BYTE_W-1:0] key_byte(input logic [FIELD_W-1:0] k,
                                                  input logic [2:0] idx);
    logic [BYTE_W-1:0] ch;
    ch = 8'h00;
    case (k)
      FIELD_VERSION: begin
        case (idx)
          3'd0:    ch = 8'h76;  // v
          3'd1:    ch = 8'h65;  // e
          3'd2:    ch = 8'h72;  // r
          3'd3:    ch = 8'h73;  // s
          3'd4:    ch = 8'h69;  // i
          3'd5:    ch = 8'h6F;  // o
          3'd6:    ch = 8'h6E;  // n
          default: ch = 8'h00;
        endcase
      end
      FIELD_URL: begin
        case (idx)
          3'd0:    ch = 8'h75;  // u
          3'd1:    ch = 8'h72;  // r
          3'd2:    ch = 8'h6C;  // l
          default: ch = 8'h00;
        endcase
      end
      FIELD_SHA: begin
        case (idx)
          3'd0:    ch = 8'h73;  // s
          3'd1:    ch = 8'h68;  // h
          3'd2:    ch = 8'h61;  // a
          3'd3:    ch = 8'h32;  // 2
          3'd4:    ch = 8'h35;  // 5
          3'd5:    ch = 8'h36;  // 6
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [CNT_W-1:0] key_len(input logic [FIELD_W-1:0] k);
    logic [CNT_W-1:0] len;
    case (k)
      FIELD_VERSION: len = KEY_LEN_VERSION;
      FIELD_URL:     len = KEY_LEN_URL;
      FIELD_SHA:     len = KEY_LEN_SHA;
      default:       len = '0;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/mfp_front.sv
// ---------------------------------------------------------------------------
// mfp_front
// Accepts manifest bytes and tags each one with its character class.
// ---------------------------------------------------------------------------
module mfp_front
  import mfp_pkg::*;
(
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_last_byte,
  output logic              push_valid,
  input  logic              push_ready,
  output mfp_item_t         push_item
);

  mfp_cls_t cls;

  always_comb begin
    cls.quote  = (in_data_byte == CH_QUOTE);
    cls.bslash = (in_data_byte == CH_BSLASH);
    cls.esc_ok = (in_data_byte == CH_QUOTE) || (in_data_byte == CH_BSLASH) ||
                 (in_data_byte == CH_SLASH);
    cls.ctrl   = (in_data_byte < CH_SPACE);
    cls.space  = (in_data_byte == CH_SPACE) || (in_data_byte == CH_TAB) ||
                 (in_data_byte == CH_LF) || (in_data_byte == CH_CR);
    cls.lbrace = (in_data_byte == CH_LBRACE);
    cls.rbrace = (in_data_byte == CH_RBRACE);
    cls.colon  = (in_data_byte == CH_COLON);
    cls.comma  = (in_data_byte == CH_COMMA);
    cls.hex    = (in_data_byte >= 8'h30 && in_data_byte <= 8'h39) ||
                 (in_data_byte >= 8'h41 && in_data_byte <= 8'h46) ||
                 (in_data_byte >= 8'h61 && in_data_byte <= 8'h66);
    cls.nul    = (in_data_byte == CH_NUL);
  end

  assign in_ready          = push_ready;
  assign push_valid        = in_valid;
  assign push_item.data    = in_data_byte;
  assign push_item.last    = in_last_byte;
  assign push_item.cls     = cls;

endmodule

// File: rtl/mfp_queue.sv
// ---------------------------------------------------------------------------
// mfp_queue
// Short flip-flop queue of classified bytes between front and back end.
// ---------------------------------------------------------------------------
module mfp_queue
  import mfp_pkg::*;
#(
  parameter int DEPTH = 2
)(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  mfp_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output mfp_item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W_Q-1:0] CNT_FULL = CNT_W_Q'(DEPTH);

  mfp_item_t            slot_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_W_Q-1:0]   count_r;
  logic                 do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!do_push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/mfp_back.sv
// ---------------------------------------------------------------------------
// mfp_back
// Parser state machine: consumes classified bytes and drives the result
// register.
// ---------------------------------------------------------------------------
`include "manifest_json_field_parser_defines.svh"

module mfp_back
  import mfp_pkg::*;
#(
  parameter int VERSION_MAX_CHARS = 32,
  parameter int URL_MAX_CHARS     = 256,
  parameter int KEY_MAX_CHARS     = 31,
  parameter int OTHER_MAX_CHARS   = 511,
  parameter int DIGEST_HEX_CHARS  = 64
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  mfp_item_t          pop_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_is_verdict,
  output logic [FIELD_W-1:0] out_field_id,
  output logic [BYTE_W-1:0]  out_value_byte,
  output logic               out_accepted
);

  typedef enum logic [3:0] {
    ST_OPEN, ST_FIRST, ST_KEY, ST_KEY_ESC, ST_COLON, ST_VAL_Q,
    ST_VAL, ST_VAL_ESC, ST_NEXT, ST_KEY_Q, ST_DONE, ST_ERR
  } phase_t;

  localparam logic [CNT_W-1:0] VER_LIM   = CNT_W'(VERSION_MAX_CHARS);
  localparam logic [CNT_W-1:0] URL_LIM   = CNT_W'(URL_MAX_CHARS);
  localparam logic [CNT_W-1:0] KEY_LIM   = CNT_W'(KEY_MAX_CHARS);
  localparam logic [CNT_W-1:0] OTHER_LIM = CNT_W'(OTHER_MAX_CHARS);
  localparam logic [CNT_W-1:0] SHA_LIM   = CNT_W'(DIGEST_HEX_CHARS);

  phase_t              phase_r, phase_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [2:0]          cand_r, cand_nxt;
  logic [FIELD_W-1:0]  field_r, field_nxt;
  logic [2:0]          seen_r, seen_nxt;
  logic                sha_ok_r, sha_ok_nxt;
  logic                emit;

  logic                out_valid_r, out_is_verdict_r, out_accepted_r;
  logic [FIELD_W-1:0]  out_field_id_r;
  logic [BYTE_W-1:0]   out_value_byte_r;

  logic                pop;
  logic [CNT_W-1:0]    val_lim;
  logic                kc_err, vc_err;
  logic [2:0]          kc_cand;
  logic [FIELD_W-1:0]  close_field;
  logic                close_dup;
  logic                verdict_ok;

  assign pop_ready = !out_valid_r || out_ready;
  assign pop       = pop_valid && pop_ready;

  // Helpers for key characters, key close and value characters.
  always_comb begin
    kc_err = (cnt_r >= KEY_LIM);
    for (int k = 0; k < 3; k++) begin
      kc_cand[k] = cand_r[k] && (cnt_r < key_len(FIELD_W'(k))) &&
                   (key_byte(FIELD_W'(k), cnt_r[2:0]) == pop_item.data);
    end
    close_field = FIELD_OTHER;
    for (int k = 0; k < 3; k++) begin
      if (cand_r[k] && (cnt_r == key_len(FIELD_W'(k)))) begin
        close_field = FIELD_W'(k);
      end
    end
    close_dup = (close_field != FIELD_OTHER) && seen_r[close_field];
    case (field_r)
      FIELD_VERSION: val_lim = VER_LIM;
      FIELD_URL:     val_lim = URL_LIM;
      FIELD_SHA:     val_lim = SHA_LIM;
      default:       val_lim = OTHER_LIM;
    endcase
    vc_err = (cnt_r >= val_lim);
  end

  // Next parser state for the byte at the queue head.
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    cand_nxt   = cand_r;
    field_nxt  = field_r;
    seen_nxt   = seen_r;
    sha_ok_nxt = sha_ok_r;
    emit       = 1'b0;
    if (!(pop_item.last && pop_item.cls.nul)) begin
      case (phase_r)
        ST_OPEN: begin
          if (pop_item.cls.lbrace) phase_nxt = ST_FIRST;
          else if (!pop_item.cls.space) phase_nxt = ST_ERR;
        end
        ST_FIRST, ST_KEY_Q: begin
          if (pop_item.cls.rbrace && phase_r == ST_FIRST) begin
            phase_nxt = ST_DONE;
          end else if (pop_item.cls.quote) begin
            phase_nxt = ST_KEY;
            cnt_nxt   = '0;
            cand_nxt  = FIELDS_ALL;
          end else if (!pop_item.cls.space) begin
            phase_nxt = ST_ERR;
          end
        end
        ST_KEY, ST_KEY_ESC: begin
          if (phase_r == ST_KEY && pop_item.cls.quote) begin
            if (close_dup) begin
              phase_nxt = ST_ERR;
            end else begin
              field_nxt = close_field;
              cnt_nxt   = '0;
              cand_nxt  = FIELDS_ALL;
              phase_nxt = ST_COLON;
            end
          end else if (phase_r == ST_KEY && pop_item.cls.bslash) begin
            phase_nxt = ST_KEY_ESC;
          end else if ((phase_r == ST_KEY && pop_item.cls.ctrl) ||
                       (phase_r == ST_KEY_ESC && !pop_item.cls.esc_ok) || kc_err) begin
            phase_nxt = ST_ERR;
          end else begin
            cand_nxt  = kc_cand;
            cnt_nxt   = cnt_r + 1'b1;
            phase_nxt = ST_KEY;
          end
        end
        ST_COLON: begin
          if (pop_item.cls.colon) phase_nxt = ST_VAL_Q;
          else if (!pop_item.cls.space) phase_nxt = ST_ERR;
        end
        ST_VAL_Q: begin
          if (pop_item.cls.quote) begin
            phase_nxt = ST_VAL;
            cnt_nxt   = '0;
          end else if (!pop_item.cls.space) begin
            phase_nxt = ST_ERR;
          end
        end
        ST_VAL, ST_VAL_ESC: begin
          if (phase_r == ST_VAL && pop_item.cls.quote) begin
            if (field_r != FIELD_OTHER) begin
              seen_nxt[field_r] = 1'b1;
              if (field_r == FIELD_SHA && cnt_r != SHA_LIM) sha_ok_nxt = 1'b0;
            end
            cnt_nxt   = '0;
            phase_nxt = ST_NEXT;
          end else if (phase_r == ST_VAL && pop_item.cls.bslash) begin
            phase_nxt = ST_VAL_ESC;
          end else if ((phase_r == ST_VAL && pop_item.cls.ctrl) ||
                       (phase_r == ST_VAL_ESC && !pop_item.cls.esc_ok) || vc_err) begin
            phase_nxt = ST_ERR;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            phase_nxt = ST_VAL;
            if (field_r == FIELD_SHA && !pop_item.cls.hex) sha_ok_nxt = 1'b0;
            emit      = (field_r != FIELD_OTHER);
          end
        end
        ST_NEXT: begin
          if (pop_item.cls.comma) phase_nxt = ST_KEY_Q;
          else if (pop_item.cls.rbrace) phase_nxt = ST_DONE;
          else if (!pop_item.cls.space) phase_nxt = ST_ERR;
        end
        ST_DONE: phase_nxt = ST_DONE;
        default: phase_nxt = ST_ERR;
      endcase
    end
  end

  assign verdict_ok = (phase_nxt == ST_DONE) && (seen_nxt == FIELDS_ALL) && sha_ok_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ST_OPEN;
      cnt_r       <= '0;
      cand_r      <= FIELDS_ALL;
      field_r     <= FIELD_VERSION;
      seen_r      <= FIELDS_NONE;
      sha_ok_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else if (pop) begin
      if (pop_item.last) begin
        phase_r          <= ST_OPEN;
        cnt_r            <= '0;
        cand_r           <= FIELDS_ALL;
        field_r          <= FIELD_VERSION;
        seen_r           <= FIELDS_NONE;
        sha_ok_r         <= 1'b1;
        out_valid_r      <= 1'b1;
        out_is_verdict_r <= 1'b1;
        out_field_id_r   <= FIELD_VERSION;
        out_value_byte_r <= '0;
        out_accepted_r   <= verdict_ok;
      end else begin
        phase_r          <= phase_nxt;
        cnt_r            <= cnt_nxt;
        cand_r           <= cand_nxt;
        field_r          <= field_nxt;
        seen_r           <= seen_nxt;
        sha_ok_r         <= sha_ok_nxt;
        out_valid_r      <= emit;
        out_is_verdict_r <= 1'b0;
        out_field_id_r   <= field_r;
        out_value_byte_r <= pop_item.data;
        out_accepted_r   <= 1'b0;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_verdict = out_is_verdict_r;
  assign out_field_id   = out_field_id_r;
  assign out_value_byte = out_value_byte_r;
  assign out_accepted   = out_accepted_r;

  `MFP_ASSERT_NEXT(a_last_gives_verdict, pop && pop_item.last, out_valid_r && out_is_verdict_r, "final byte did not produce a verdict")
  `MFP_ASSERT_NEXT(a_last_resets_state, pop && pop_item.last, phase_r == ST_OPEN && seen_r == FIELDS_NONE && sha_ok_r, "parser state not cleared after verdict")
  `MFP_ASSERT_NEXT(a_error_swallows, phase_r == ST_ERR && pop && !pop_item.last, phase_r == ST_ERR && !out_valid_r, "byte after an error left the error state or produced a result")
  `MFP_ASSERT_NOW(a_char_is_known_field, out_valid_r && !out_is_verdict_r, out_field_id_r != FIELD_OTHER && !out_accepted_r, "value character tagged with an unknown field")

endmodule

// File: rtl/manifest_json_field_parser.sv
// ---------------------------------------------------------------------------
// manifest_json_field_parser
// Streaming checker and field extractor for a flat JSON manifest of strings.
// ---------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   -------  -------------------  -------------------------------------------------
//   input    in_valid/in_ready    in_data_byte, in_last_byte
//   result   out_valid/out_ready  out_is_verdict, out_field_id, out_value_byte,
//                                 out_accepted
//
// One byte is accepted per cycle while the queue has room; the parser updates its
// state for each byte it pops. A byte's result is registered in the output register
// after the byte has passed through the two-entry queue, behind any entries ahead of it.
// Reset is synchronous and active low: it empties the queue, drops any pending
// result and returns the parser to waiting for an opening brace.
// A stalled result side fills the output register, then the queue, then drops in_ready.
//
// The front end tags each byte with its character class (quote, backslash,
// whitespace, structural characters, hex digit, control byte, NUL). The back
// end walks the object grammar: keys are matched against version, url and
// sha256 one character at a time, and characters of known values are emitted
// as value transactions tagged with their field. A repeated known key, an
// over-long key or value, a bad escape, a raw control byte or a misplaced
// token sends the parser to an error state that swallows everything up to
// the final byte. The final byte always yields a verdict transaction; a final
// NUL is dropped first. Accept needs a closed object, all three fields and a
// sha256 value of exactly DIGEST_HEX_CHARS hex digits.
// ---------------------------------------------------------------------------
module manifest_json_field_parser
  import mfp_pkg::*;
#(
  parameter int VERSION_MAX_CHARS = 32,
  parameter int URL_MAX_CHARS     = 256,
  parameter int KEY_MAX_CHARS     = 31,
  parameter int OTHER_MAX_CHARS   = 511,
  parameter int DIGEST_HEX_CHARS  = 64
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BYTE_W-1:0]  in_data_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_is_verdict,
  output logic [FIELD_W-1:0] out_field_id,
  output logic [BYTE_W-1:0]  out_value_byte,
  output logic               out_accepted
);

  // Classified byte on its way into the queue.
  logic      push_valid, push_ready;
  mfp_item_t push_item;

  // Head of the queue as seen by the parser.
  logic      pop_valid, pop_ready;
  mfp_item_t pop_item;

  mfp_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  // The queue lets the classifier keep accepting while the result register
  // waits on the downstream side.
  mfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // The parser owns all grammar state and the registered result.
  mfp_back #(
    .VERSION_MAX_CHARS (VERSION_MAX_CHARS),
    .URL_MAX_CHARS     (URL_MAX_CHARS),
    .KEY_MAX_CHARS     (KEY_MAX_CHARS),
    .OTHER_MAX_CHARS   (OTHER_MAX_CHARS),
    .DIGEST_HEX_CHARS  (DIGEST_HEX_CHARS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_item       (pop_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_is_verdict (out_is_verdict),
    .out_field_id   (out_field_id),
    .out_value_byte (out_value_byte),
    .out_accepted   (out_accepted)
  );

endmodule

// File: test/tb_manifest_json_field_parser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_manifest_json_field_parser
// Self-checking testbench for the streaming manifest parser. A short table of
// hand-written bytes is followed by randomly built manifests, mostly
// well-formed with random content, some broken and some pure noise. Every
// accepted byte is run through a parser model kept in this file, and every
// result transaction is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_manifest_json_field_parser
  import mfp_pkg::*;
();

  // Limits of the block, kept equal to the values the instance is built with.
  localparam int VERSION_MAX_CHARS = 32;
  localparam int URL_MAX_CHARS     = 256;
  localparam int KEY_MAX_CHARS     = 31;
  localparam int OTHER_MAX_CHARS   = 511;
  localparam int DIGEST_HEX_CHARS  = 64;

  // Random manifests are sent until this many random bytes have gone in.
  localparam int MIN_RANDOM_BYTES  = 450;

  // Window of random bytes that is sent with no idling on either side.
  localparam int BURST_FROM        = 150;
  localparam int BURST_TO          = 300;

  // Cycles without any transaction before the run is declared hung. The
  // limit is set wide.
  localparam int STALL_LIMIT       = 2000;
  localparam int TAIL_CYCLES       = 8;
  localparam int REPORT_LIMIT      = 10;

  // A letter that is not a legal escape character.
  localparam logic [BYTE_W-1:0] CH_LOWER_N = 8'h6E;

  // Grammar positions of the parser model.
  typedef enum logic [3:0] {
    ST_WAIT_OPEN,
    ST_FIRST_KEY,
    ST_KEY,
    ST_KEY_ESC,
    ST_COLON,
    ST_VALUE_QUOTE,
    ST_VALUE,
    ST_VALUE_ESC,
    ST_AFTER_VALUE,
    ST_KEY_QUOTE,
    ST_CLOSED,
    ST_FAILED
  } parse_state_t;

  // One result transaction as seen on the out_ ports.
  typedef struct packed {
    logic               verdict;
    logic [FIELD_W-1:0] fid;
    logic [BYTE_W-1:0]  vbyte;
    logic               acc;
  } result_t;

  // One row of the opening table. Rows with fixed set carry a verdict whose
  // outcome is typed in; all other rows are checked against the model.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              fixed;
    logic              accept;
  } stim_row_t;

  localparam int N_ROWS = 25;

  // The rows walk through: a lone final NUL right after reset, a lone final
  // 0xFF, then a url-only object laced with every kind of whitespace and all
  // three legal escapes, a byte after the closing brace that must be ignored,
  // and a final NUL that is dropped before a verdict that rejects, because
  // version and sha256 are missing.
  stim_row_t opening_rows [N_ROWS] = '{
    '{CH_NUL,    1'b1, 1'b1, 1'b0},
    '{8'hFF,     1'b1, 1'b1, 1'b0},
    '{CH_SPACE,  1'b0, 1'b0, 1'b0},
    '{CH_LBRACE, 1'b0, 1'b0, 1'b0},
    '{CH_TAB,    1'b0, 1'b0, 1'b0},
    '{CH_QUOTE,  1'b0, 1'b0, 1'b0},
    '{"u",       1'b0, 1'b0, 1'b0},
    '{"r",       1'b0, 1'b0, 1'b0},
    '{"l",       1'b0, 1'b0, 1'b0},
    '{CH_QUOTE,  1'b0, 1'b0, 1'b0},
    '{CH_CR,     1'b0, 1'b0, 1'b0},
    '{CH_COLON,  1'b0, 1'b0, 1'b0},
    '{CH_LF,     1'b0, 1'b0, 1'b0},
    '{CH_QUOTE,  1'b0, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0},
    '{CH_SLASH,  1'b0, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0},
    '{CH_BSLASH, 1'b0, 1'b0, 1'b0},
    '{CH_QUOTE,  1'b0, 1'b0, 1'b0},
    '{"~",       1'b0, 1'b0, 1'b0},
    '{CH_QUOTE,  1'b0, 1'b0, 1'b0},
    '{CH_RBRACE, 1'b0, 1'b0, 1'b0},
    '{8'hFF,     1'b0, 1'b0, 1'b0},
    '{CH_NUL,    1'b1, 1'b1, 1'b0}
  };

  // Known key names, indexed by field code: version, url, sha256.
  string key_names [3] = '{"version", "url", "sha256"};
  string hex_digits = "0123456789abcdefABCDEF";

  // Clock, reset and every input of the block start at a known value.
  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic [BYTE_W-1:0]  in_data_byte = '0;
  logic               in_last_byte = 1'b0;
  logic               out_ready    = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic               out_is_verdict;
  logic [FIELD_W-1:0] out_field_id;
  logic [BYTE_W-1:0]  out_value_byte;
  logic               out_accepted;

  // Parser model state.
  parse_state_t       ph;
  logic [9:0]         nchar;
  logic [2:0]         cand;
  logic [FIELD_W-1:0] fld;
  logic [2:0]         seen;
  logic               hex_ok;

  // Predicted result transactions, oldest first.
  result_t            pending_results [$];

  // The manifest currently being built by the generator.
  logic [BYTE_W-1:0]  mbytes [$];

  // Random idling is switched off for a stretch of bytes.
  bit                 gaps_on = 1'b1;

  int                 errors;
  int                 bytes_sent;
  int                 manifests;
  int                 values_seen;
  int                 verdicts_seen;
  int                 accepts_seen;
  int                 quiet_cycles;

  manifest_json_field_parser #(
    .VERSION_MAX_CHARS (VERSION_MAX_CHARS),
    .URL_MAX_CHARS     (URL_MAX_CHARS),
    .KEY_MAX_CHARS     (KEY_MAX_CHARS),
    .OTHER_MAX_CHARS   (OTHER_MAX_CHARS),
    .DIGEST_HEX_CHARS  (DIGEST_HEX_CHARS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_is_verdict (out_is_verdict),
    .out_field_id   (out_field_id),
    .out_value_byte (out_value_byte),
    .out_accepted   (out_accepted)
  );

  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // Parser model
  // -------------------------------------------------------------------------

  function automatic void clear_parser();
    ph     = ST_WAIT_OPEN;
    nchar  = '0;
    cand   = 3'b111;
    fld    = FIELD_VERSION;
    seen   = FIELDS_NONE;
    hex_ok = 1'b1;
  endfunction

  function automatic bit is_ws(input logic [BYTE_W-1:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
  endfunction

  function automatic bit is_escapable(input logic [BYTE_W-1:0] b);
    return b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH;
  endfunction

  function automatic bit is_hexdig(input logic [BYTE_W-1:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
  endfunction

  function automatic int limit_of(input logic [FIELD_W-1:0] f);
    case (f)
      FIELD_VERSION: return VERSION_MAX_CHARS;
      FIELD_URL:     return URL_MAX_CHARS;
      FIELD_SHA:     return DIGEST_HEX_CHARS;
      default:       return OTHER_MAX_CHARS;
    endcase
  endfunction

  function automatic void open_key();
    ph    = ST_KEY;
    nchar = '0;
    cand  = 3'b111;
  endfunction

  // A key character narrows the set of known keys it can still spell.
  function automatic void take_key_char(input logic [BYTE_W-1:0] c);
    if (nchar >= KEY_MAX_CHARS) begin
      ph = ST_FAILED;
      return;
    end
    for (int k = 0; k < 3; k++) begin
      if (nchar >= key_names[k].len() || key_names[k][nchar] != c) cand[k] = 1'b0;
    end
    nchar = nchar + 1'b1;
    ph = ST_KEY;
  endfunction

  function automatic void close_key();
    logic [FIELD_W-1:0] f;
    f = FIELD_OTHER;
    for (int k = 0; k < 3; k++) begin
      if (cand[k] && nchar == key_names[k].len()) f = FIELD_W'(k);
    end
    if (f != FIELD_OTHER && seen[f]) begin
      ph = ST_FAILED;
      return;
    end
    fld   = f;
    nchar = '0;
    cand  = 3'b111;
    ph    = ST_COLON;
  endfunction

  // Returns 1 when the character is emitted as a value transaction.
  function automatic bit take_value_char(input logic [BYTE_W-1:0] c);
    if (nchar >= limit_of(fld)) begin
      ph = ST_FAILED;
      return 1'b0;
    end
    nchar = nchar + 1'b1;
    ph = ST_VALUE;
    if (fld == FIELD_SHA && !is_hexdig(c)) hex_ok = 1'b0;
    return fld != FIELD_OTHER;
  endfunction

  function automatic void close_value();
    if (fld != FIELD_OTHER) begin
      seen[fld] = 1'b1;
      if (fld == FIELD_SHA && nchar != DIGEST_HEX_CHARS) hex_ok = 1'b0;
    end
    nchar = '0;
    ph = ST_AFTER_VALUE;
  endfunction

  function automatic bit parse_char(input logic [BYTE_W-1:0] b);
    bit emit;
    emit = 1'b0;
    case (ph)
      ST_WAIT_OPEN: begin
        if (b == CH_LBRACE) ph = ST_FIRST_KEY;
        else if (!is_ws(b)) ph = ST_FAILED;
      end
      ST_FIRST_KEY: begin
        if (b == CH_RBRACE) ph = ST_CLOSED;
        else if (b == CH_QUOTE) open_key();
        else if (!is_ws(b)) ph = ST_FAILED;
      end
      ST_KEY_QUOTE: begin
        if (b == CH_QUOTE) open_key();
        else if (!is_ws(b)) ph = ST_FAILED;
      end
      ST_KEY: begin
        if (b == CH_QUOTE) close_key();
        else if (b == CH_BSLASH) ph = ST_KEY_ESC;
        else if (b < CH_SPACE) ph = ST_FAILED;
        else take_key_char(b);
      end
      ST_KEY_ESC: begin
        if (is_escapable(b)) take_key_char(b);
        else ph = ST_FAILED;
      end
      ST_COLON: begin
        if (b == CH_COLON) ph = ST_VALUE_QUOTE;
        else if (!is_ws(b)) ph = ST_FAILED;
      end
      ST_VALUE_QUOTE: begin
        if (b == CH_QUOTE) begin
          ph = ST_VALUE;
          nchar = '0;
        end else if (!is_ws(b)) begin
          ph = ST_FAILED;
        end
      end
      ST_VALUE: begin
        if (b == CH_QUOTE) close_value();
        else if (b == CH_BSLASH) ph = ST_VALUE_ESC;
        else if (b < CH_SPACE) ph = ST_FAILED;
        else emit = take_value_char(b);
      end
      ST_VALUE_ESC: begin
        if (is_escapable(b)) emit = take_value_char(b);
        else ph = ST_FAILED;
      end
      ST_AFTER_VALUE: begin
        if (b == CH_COMMA) ph = ST_KEY_QUOTE;
        else if (b == CH_RBRACE) ph = ST_CLOSED;
        else if (!is_ws(b)) ph = ST_FAILED;
      end
      ST_CLOSED: begin
        // Anything after the closing brace is ignored.
      end
      default: ph = ST_FAILED;
    endcase
    return emit;
  endfunction

  // Runs one accepted byte through the model and queues what it yields. A
  // fixed row replaces the predicted verdict outcome with the typed one.
  function automatic void parse_step(input logic [BYTE_W-1:0] b, input logic lst,
                                     input logic fixed, input logic fixed_acc);
    result_t            r;
    logic [FIELD_W-1:0] fid;
    fid = fld;
    r   = '0;
    if (!lst) begin
      if (parse_char(b)) begin
        r.fid   = fid;
        r.vbyte = b;
        pending_results.push_back(r);
      end
    end else begin
      // A final NUL is dropped; any other final byte is parsed but never
      // emitted as a value character.
      if (b != CH_NUL) void'(parse_char(b));
      r.verdict = 1'b1;
      r.acc = (ph == ST_CLOSED && seen == FIELDS_ALL && hex_ok) ? 1'b1 : 1'b0;
      if (fixed) r.acc = fixed_acc;
      pending_results.push_back(r);
      clear_parser();
    end
  endfunction

  // -------------------------------------------------------------------------
  // Manifest generator
  // -------------------------------------------------------------------------

  function automatic void put_ws();
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(3))
          0:       mbytes.push_back(CH_SPACE);
          1:       mbytes.push_back(CH_TAB);
          2:       mbytes.push_back(CH_LF);
          default: mbytes.push_back(CH_CR);
        endcase
      end
    end
  endfunction

  function automatic void put_string(input string s);
    for (int i = 0; i < s.len(); i++) mbytes.push_back(s[i]);
  endfunction

  // One string character: mostly printable, often high bytes or a legal
  // escape, and very rarely a control byte or an illegal escape.
  function automatic void put_text_char();
    int                r;
    logic [BYTE_W-1:0] c;
    r = $urandom_range(999);
    if (r == 0) begin
      if ($urandom_range(1) == 0) begin
        mbytes.push_back(8'($urandom_range(31)));
      end else begin
        mbytes.push_back(CH_BSLASH);
        mbytes.push_back(CH_LOWER_N);
      end
    end else if (r < 120) begin
      mbytes.push_back(CH_BSLASH);
      case ($urandom_range(2))
        0:       mbytes.push_back(CH_QUOTE);
        1:       mbytes.push_back(CH_BSLASH);
        default: mbytes.push_back(CH_SLASH);
      endcase
    end else if (r < 220) begin
      mbytes.push_back(8'($urandom_range(128, 255)));
    end else begin
      do c = 8'($urandom_range(32, 126)); while (c == CH_QUOTE || c == CH_BSLASH);
      mbytes.push_back(c);
    end
  endfunction

  // Keys that are not one of the three: near misses of a known key, keys
  // around the length limit, and short random ones.
  function automatic void put_unknown_key();
    int k;
    k = $urandom_range(2);
    case ($urandom_range(4))
      0: put_string(key_names[k].substr(0, key_names[k].len() - 2));
      1: begin
        put_string(key_names[k]);
        put_text_char();
      end
      2: repeat ($urandom_range(KEY_MAX_CHARS - 1, KEY_MAX_CHARS + 2)) put_text_char();
      default: repeat ($urandom_range(8)) put_text_char();
    endcase
  endfunction

  // Value lengths sit mostly well inside the limit, sometimes at it and now
  // and then one past it. The digest is mostly exact hex of mixed case.
  function automatic void put_value(input logic [FIELD_W-1:0] code);
    int n;
    int r;
    int bad;
    r   = $urandom_range(99);
    bad = -1;
    case (code)
      FIELD_VERSION: begin
        if (r < 10) n = 0;
        else if (r < 80) n = $urandom_range(1, 12);
        else if (r < 95) n = $urandom_range(VERSION_MAX_CHARS - 1, VERSION_MAX_CHARS);
        else n = VERSION_MAX_CHARS + 1;
      end
      FIELD_URL: begin
        if (r < 90) n = $urandom_range(24);
        else if (r < 97) n = $urandom_range(URL_MAX_CHARS - 2, URL_MAX_CHARS);
        else n = URL_MAX_CHARS + 1;
      end
      FIELD_SHA: begin
        if (r < 82) n = DIGEST_HEX_CHARS;
        else if (r < 90) n = DIGEST_HEX_CHARS - 1 + 2 * $urandom_range(1);
        else if (r < 95) n = DIGEST_HEX_CHARS;
        else n = $urandom_range(5);
        if (r >= 90 && r < 95) bad = $urandom_range(n - 1);
      end
      default: begin
        if (r < 92) n = $urandom_range(10);
        else if (r < 98) n = $urandom_range(OTHER_MAX_CHARS - 2, OTHER_MAX_CHARS);
        else n = OTHER_MAX_CHARS + 1;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      if (code != FIELD_SHA) put_text_char();
      else if (i == bad) mbytes.push_back("g");
      else mbytes.push_back(hex_digits[$urandom_range(21)]);
    end
  endfunction

  // Builds one manifest into mbytes.
  function automatic void build_manifest();
    logic [FIELD_W-1:0] order [$];
    logic [FIELD_W-1:0] tmp;
    int                 j;
    int                 r;
    mbytes.delete();
    if ($urandom_range(99) < 8) begin
      // Noise: a few bytes of anything, sometimes behind an opening brace.
      repeat ($urandom_range(1, 6)) mbytes.push_back(8'($urandom_range(255)));
      if ($urandom_range(1) == 0) mbytes[0] = CH_LBRACE;
      return;
    end
    if ($urandom_range(9) != 0) order.push_back(FIELD_VERSION);
    if ($urandom_range(9) != 0) order.push_back(FIELD_URL);
    if ($urandom_range(9) != 0) order.push_back(FIELD_SHA);
    repeat ($urandom_range(2)) order.push_back(FIELD_OTHER);
    if ($urandom_range(19) == 0) order.push_back(FIELD_W'($urandom_range(2)));
    for (int i = order.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    put_ws();
    mbytes.push_back(CH_LBRACE);
    foreach (order[i]) begin
      if (i > 0) mbytes.push_back(CH_COMMA);
      put_ws();
      mbytes.push_back(CH_QUOTE);
      if (order[i] == FIELD_OTHER) put_unknown_key();
      else put_string(key_names[order[i]]);
      mbytes.push_back(CH_QUOTE);
      put_ws();
      mbytes.push_back(CH_COLON);
      put_ws();
      mbytes.push_back(CH_QUOTE);
      put_value(order[i]);
      mbytes.push_back(CH_QUOTE);
      put_ws();
    end
    mbytes.push_back(CH_RBRACE);
    // The closing brace is the final byte, or a NUL or some junk follows.
    case ($urandom_range(2))
      0: ;
      1: mbytes.push_back(CH_NUL);
      default: repeat ($urandom_range(1, 3)) mbytes.push_back(8'($urandom_range(255)));
    endcase
    // Broken manifests: a byte replaced, a byte dropped or the text cut short.
    r = $urandom_range(99);
    if (r < 8) begin
      mbytes[$urandom_range(mbytes.size() - 1)] = 8'($urandom_range(255));
    end else if (r < 12) begin
      mbytes.delete($urandom_range(mbytes.size() - 1));
    end else if (r < 15) begin
      j = $urandom_range(1, mbytes.size());
      while (mbytes.size() > j) void'(mbytes.pop_back());
    end
  endfunction

  // -------------------------------------------------------------------------
  // Driving and checking
  // -------------------------------------------------------------------------

  // Presents one byte as an input transaction. It is entered at a falling
  // edge and returns at the falling edge after the byte was accepted, so
  // in_valid stays high between back-to-back bytes without being lowered.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lst,
                           input logic fixed, input logic fixed_acc);
    while (gaps_on && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_step(b, lst, fixed, fixed_acc);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic void note_mismatch(input string what, input result_t want,
                                        input result_t got);
    errors++;
    if (errors <= REPORT_LIMIT) begin
      $display("%s: expected verdict=%0d field=%0d byte=%02h acc=%0d, got verdict=%0d field=%0d byte=%02h acc=%0d",
               what, want.verdict, want.fid, want.vbyte, want.acc,
               got.verdict, got.fid, got.vbyte, got.acc);
    end
  endfunction

  // The result side stalls at random, except in the stretch without gaps.
  always @(negedge clk) begin
    out_ready <= gaps_on ? ($urandom_range(99) >= 33) : 1'b1;
  end

  // Compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_is_verdict, out_field_id, out_value_byte, out_accepted};
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got != want) note_mismatch("mismatch", want, got);
        if (want.verdict) begin
          verdicts_seen++;
          if (want.acc) accepts_seen++;
        end else begin
          values_seen++;
        end
      end
    end
  end

  // Watchdog: the run is hung when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("tb_manifest_json_field_parser: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_parser();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Opening table, with random idling on both sides.
    foreach (opening_rows[i]) begin
      send_byte(opening_rows[i].data, opening_rows[i].last, opening_rows[i].fixed,
                opening_rows[i].accept);
    end

    // Random manifests. A window of bytes runs with no idling at all so that
    // the block is seen at full rate.
    bytes_sent = 0;
    while (bytes_sent < MIN_RANDOM_BYTES) begin
      build_manifest();
      foreach (mbytes[i]) begin
        gaps_on = !(bytes_sent >= BURST_FROM && bytes_sent < BURST_TO);
        send_byte(mbytes[i], i == mbytes.size() - 1, 1'b0, 1'b0);
      end
      manifests++;
    end
    gaps_on = 1'b1;
    in_valid <= 1'b0;

    // Let outstanding results drain, then idle through a short tail so that any
    // stray transaction can still show up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d random manifests in %0d random bytes after the opening table.",
             manifests, bytes_sent);
    $display("Checked %0d value characters and %0d verdicts, %0d of them accepting.",
             values_seen, verdicts_seen, accepts_seen);
    if (errors == 0) begin
      $display("tb_manifest_json_field_parser: clean");
    end else begin
      $display("tb_manifest_json_field_parser: errors");
    end
    $finish;
  end

endmodule

// File: manifest_json_field_parser.f
+incdir+rtl
rtl/mfp_pkg.sv
rtl/mfp_front.sv
rtl/mfp_queue.sv
rtl/mfp_back.sv
rtl/manifest_json_field_parser.sv
test/tb_manifest_json_field_parser.sv
